>>> hdl/dtmfg_pkg.sv
// Shared constants, key decode tables and sine table builder for the DTMF generator.
`default_nettype none

package dtmfg_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned KEY_W       = 4;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned ROM_W       = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_TONE_TICKS   = CFG_INDEX_W'(1);

  localparam logic [COUNT_W-1:0] SETTLE_TICKS_RESET = COUNT_W'(32000);
  localparam logic [COUNT_W-1:0] TONE_TICKS_RESET   = COUNT_W'(32000);
  localparam logic [KEY_W-1:0]   KEYS_RESET         = KEY_W'(15);

  localparam logic [63:0] SAMPLE_RATE = 64'd16000;
  localparam logic [63:0] HALF_RATE   = 64'd8000;
  localparam logic [63:0] AMPLITUDE   = 64'd10000;

  localparam logic [63:0] ROW_FREQ [4] = '{64'd697, 64'd770, 64'd852, 64'd941};
  localparam logic [63:0] COL_FREQ [3] = '{64'd1209, 64'd1336, 64'd1477};

  // row and column index per key code; codes below four carry no tone
  localparam logic [1:0] KEY_ROW [16] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd3, 2'd3, 2'd2, 2'd2,
    2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd3
  };
  localparam logic [1:0] KEY_COL [16] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1,
    2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd1
  };
  localparam logic [15:0] KEY_VALID = 16'hFFF0;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    return prod[125:62];
  endfunction

  // restoring long division, used at elaboration only
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] sine_mag(input logic [63:0] p, input logic [63:0] n);
    logic        use_cos;
    logic [63:0] q;
    logic [63:0] r;
    logic [64:0] rem;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] k;
    use_cos = ((p << 1) > n);
    q = use_cos ? n - p : p;
    r = '0;
    rem = {1'b0, q};
    for (int s = 0; s < 62; s++) begin
      rem = rem << 1;
      r = r << 1;
      if (rem >= {1'b0, n}) begin
        rem = rem - {1'b0, n};
        r[0] = 1'b1;
      end
    end
    x = mul_q62(HALF_PI_Q62, r);
    x2 = mul_q62(x, x);
    if (use_cos) begin
      sum = ONE_Q62;
      term = ONE_Q62;
      for (int j = 1; j <= 16; j++) begin
        k = 64'(j);
        term = div_u64(mul_q62(term, x2), (2 * k - 1) * (2 * k));
        if (j % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
    end else begin
      sum = x;
      term = x;
      for (int j = 1; j <= 16; j++) begin
        k = 64'(j);
        term = div_u64(mul_q62(term, x2), (2 * k) * (2 * k + 1));
        if (j % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    return 64'(mul_q62(sum, AMPLITUDE) & 64'hFFFF_FFFF);
  endfunction

  function automatic logic signed [ROM_W-1:0] rom_entry(input logic [63:0] i,
                                                       input logic [63:0] depth);
    logic [63:0] p;
    logic        neg;
    logic [63:0] mag;
    p = i << 2;
    neg = 1'b0;
    if (p >= (depth << 1)) begin
      neg = 1'b1;
      p = p - (depth << 1);
    end
    if (p > depth) p = (depth << 1) - p;
    if (p == 64'd0) mag = 64'd0;
    else if (p == depth) mag = AMPLITUDE;
    else if (3 * p == depth) mag = AMPLITUDE >> 1;
    else mag = sine_mag(p, depth);
    return neg ? -ROM_W'(mag) : ROM_W'(mag);
  endfunction

endpackage

`default_nettype wire

>>> hdl/dtmfg_sine_rom.sv
// Sine ROM with two registered read ports.
`default_nettype none

module dtmfg_sine_rom #(
  parameter int unsigned TABLE_DEPTH = 512,
  parameter int unsigned ADDR_W      = 9
) (
  input  wire logic                                  clk,
  input  wire logic                                  rd_en,
  input  wire logic [ADDR_W-1:0]                     row_addr,
  input  wire logic [ADDR_W-1:0]                     col_addr,
  output      logic signed [dtmfg_pkg::ROM_W-1:0]    row_data,
  output      logic signed [dtmfg_pkg::ROM_W-1:0]    col_data
);

  typedef logic signed [dtmfg_pkg::ROM_W-1:0] rom_t [TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < int'(TABLE_DEPTH); i++) begin
      r[i] = dtmfg_pkg::rom_entry(64'(i), 64'(TABLE_DEPTH));
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_data <= SINE_ROM[row_addr];
      col_data <= SINE_ROM[col_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/dtmfg_ctrl.sv
// Debounce, tone timing, configuration registers and phase accumulators.
`default_nettype none

module dtmfg_ctrl #(
  parameter int unsigned TABLE_DEPTH     = 512,
  parameter int unsigned PHASE_FRAC_BITS = 16,
  parameter int unsigned ADDR_W          = 9
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [dtmfg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [dtmfg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                                accept,
  input  wire logic [dtmfg_pkg::KEY_W-1:0]         keys,
  output      logic                                active,
  output      logic [ADDR_W-1:0]                   row_addr,
  output      logic [ADDR_W-1:0]                   col_addr
);

  localparam int unsigned PHASE_W = ADDR_W + PHASE_FRAC_BITS;
  localparam logic [63:0] SCALE   = 64'(TABLE_DEPTH) << PHASE_FRAC_BITS;
  localparam logic [PHASE_W:0] MODULUS = (PHASE_W + 1)'(SCALE);

  localparam logic [63:0] ROW_STEP [4] = '{
    (dtmfg_pkg::ROW_FREQ[0] * SCALE + dtmfg_pkg::HALF_RATE) / dtmfg_pkg::SAMPLE_RATE,
    (dtmfg_pkg::ROW_FREQ[1] * SCALE + dtmfg_pkg::HALF_RATE) / dtmfg_pkg::SAMPLE_RATE,
    (dtmfg_pkg::ROW_FREQ[2] * SCALE + dtmfg_pkg::HALF_RATE) / dtmfg_pkg::SAMPLE_RATE,
    (dtmfg_pkg::ROW_FREQ[3] * SCALE + dtmfg_pkg::HALF_RATE) / dtmfg_pkg::SAMPLE_RATE
  };
  localparam logic [63:0] COL_STEP [3] = '{
    (dtmfg_pkg::COL_FREQ[0] * SCALE + dtmfg_pkg::HALF_RATE) / dtmfg_pkg::SAMPLE_RATE,
    (dtmfg_pkg::COL_FREQ[1] * SCALE + dtmfg_pkg::HALF_RATE) / dtmfg_pkg::SAMPLE_RATE,
    (dtmfg_pkg::COL_FREQ[2] * SCALE + dtmfg_pkg::HALF_RATE) / dtmfg_pkg::SAMPLE_RATE
  };

  logic [dtmfg_pkg::COUNT_W-1:0] settle_ticks;
  logic [dtmfg_pkg::COUNT_W-1:0] tone_ticks;
  logic [dtmfg_pkg::KEY_W-1:0]   latched_keys, latched_keys_next;
  logic [dtmfg_pkg::COUNT_W-1:0] settle_count, settle_count_next;
  logic [dtmfg_pkg::COUNT_W-1:0] tone_count, tone_count_next;
  logic                          tone_on, tone_on_next;
  logic [PHASE_W-1:0]            row_phase, row_phase_next;
  logic [PHASE_W-1:0]            column_phase, column_phase_next;

  logic [dtmfg_pkg::COUNT_W-1:0] settle_inc;
  logic [dtmfg_pkg::COUNT_W-1:0] tone_inc;
  logic [1:0]                    row_sel;
  logic [1:0]                    col_sel;
  logic [PHASE_W-1:0]            row_step;
  logic [PHASE_W-1:0]            col_step;
  logic [PHASE_W:0]              row_sum;
  logic [PHASE_W:0]              col_sum;
  logic [PHASE_W-1:0]            row_adv;
  logic [PHASE_W-1:0]            col_adv;

  assign active   = tone_on;
  assign row_addr = row_phase[PHASE_W-1:PHASE_FRAC_BITS];
  assign col_addr = column_phase[PHASE_W-1:PHASE_FRAC_BITS];

  always_comb begin
    settle_inc = (settle_count == '1) ? settle_count : settle_count + 1'b1;
    tone_inc   = (tone_count == '1) ? tone_count : tone_count + 1'b1;
    row_sel    = dtmfg_pkg::KEY_ROW[latched_keys];
    col_sel    = dtmfg_pkg::KEY_COL[latched_keys];
    row_step   = PHASE_W'(ROW_STEP[row_sel]);
    col_step   = (col_sel == 2'd2) ? PHASE_W'(COL_STEP[2]) :
                 (col_sel == 2'd1) ? PHASE_W'(COL_STEP[1]) : PHASE_W'(COL_STEP[0]);
    row_sum    = {1'b0, row_phase} + {1'b0, row_step};
    col_sum    = {1'b0, column_phase} + {1'b0, col_step};
    row_adv    = (row_sum >= MODULUS) ? PHASE_W'(row_sum - MODULUS) : PHASE_W'(row_sum);
    col_adv    = (col_sum >= MODULUS) ? PHASE_W'(col_sum - MODULUS) : PHASE_W'(col_sum);

    latched_keys_next = latched_keys;
    settle_count_next = settle_count;
    tone_count_next   = tone_count;
    tone_on_next      = tone_on;
    row_phase_next    = row_phase;
    column_phase_next = column_phase;

    if (tone_on) begin
      if (dtmfg_pkg::KEY_VALID[latched_keys]) begin
        row_phase_next    = row_adv;
        column_phase_next = col_adv;
      end
      tone_count_next = tone_inc;
      if (tone_inc > tone_ticks) begin
        tone_count_next = '0;
        tone_on_next    = 1'b0;
      end
    end else begin
      if (keys == latched_keys) begin
        settle_count_next = settle_inc;
      end else begin
        settle_count_next = '0;
        latched_keys_next = keys;
      end
      if (settle_count_next > settle_ticks) begin
        settle_count_next = '0;
        tone_on_next      = 1'b1;
        row_phase_next    = '0;
        column_phase_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks <= dtmfg_pkg::SETTLE_TICKS_RESET;
      tone_ticks   <= dtmfg_pkg::TONE_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtmfg_pkg::REG_SETTLE_TICKS: settle_ticks <= cfg_data;
        dtmfg_pkg::REG_TONE_TICKS:   tone_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_keys <= dtmfg_pkg::KEYS_RESET;
      settle_count <= '0;
      tone_count   <= '0;
      tone_on      <= 1'b0;
      row_phase    <= '0;
      column_phase <= '0;
    end else if (accept) begin
      latched_keys <= latched_keys_next;
      settle_count <= settle_count_next;
      tone_count   <= tone_count_next;
      tone_on      <= tone_on_next;
      row_phase    <= row_phase_next;
      column_phase <= column_phase_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/dtmf_tone_generator.sv
// DTMF tone generator top level: handshake, ROM read stage and output word register.
// Each accepted input word passes the sine ROM read stage and then the output word register.
// Throughput: one word per cycle; the two-port sine ROM read is the only registered stage
// ahead of the output register, and input stalls only while both are full and blocked.
// Reset: synchronous, active high; clears the pipeline, restores both tick registers to
// 32000, latches key code 15 and stops any tone.
`default_nettype none

module dtmf_tone_generator #(
  parameter int unsigned TABLE_DEPTH     = 512,
  parameter int unsigned PHASE_FRAC_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output      logic                                   in_stall,
  input  wire logic [dtmfg_pkg::KEY_W-1:0]            key_switches,
  output      logic                                   out_valid,
  input  wire logic                                   out_stall,
  output      logic signed [dtmfg_pkg::SAMPLE_W-1:0]  audio_sample,
  output      logic                                   tone_active,
  input  wire logic                                   cfg_valid,
  output      logic                                   cfg_ready,
  input  wire logic [dtmfg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [dtmfg_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

  logic                                 accept;
  logic                                 can_out;
  logic                                 active;
  logic [ADDR_W-1:0]                    row_addr;
  logic [ADDR_W-1:0]                    col_addr;
  logic signed [dtmfg_pkg::ROM_W-1:0]   row_data;
  logic signed [dtmfg_pkg::ROM_W-1:0]   col_data;
  logic                                 rd_valid;
  logic                                 rd_active;
  logic signed [dtmfg_pkg::SAMPLE_W-1:0] sum;

  assign cfg_ready = 1'b1;
  assign can_out   = !out_valid || !out_stall;
  assign in_stall  = rd_valid && !can_out;
  assign accept    = in_valid && !in_stall;
  assign sum       = rd_active ?
                     dtmfg_pkg::SAMPLE_W'(row_data) + dtmfg_pkg::SAMPLE_W'(col_data) : '0;

  dtmfg_ctrl #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
    .ADDR_W          (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .keys      (key_switches),
    .active    (active),
    .row_addr  (row_addr),
    .col_addr  (col_addr)
  );

  dtmfg_sine_rom #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_rom (
    .clk      (clk),
    .rd_en    (accept),
    .row_addr (row_addr),
    .col_addr (col_addr),
    .row_data (row_data),
    .col_data (col_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (accept) begin
      rd_valid <= 1'b1;
    end else if (can_out) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_active <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_out) begin
      out_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_out && rd_valid) begin
      audio_sample <= sum;
      tone_active  <= rd_active;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> rd_valid && out_valid && out_stall)
    else $error("input stalled while pipeline had room");

  a_idle_word_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tone_active |-> audio_sample == '0)
    else $error("nonzero sample outside a tone");

  a_accept_fills_rd: assert property (@(posedge clk) disable iff (rst)
    accept |=> rd_valid)
    else $error("accepted word lost before ROM stage");

  a_rd_drains: assert property (@(posedge clk) disable iff (rst)
    rd_valid && can_out && !accept |=> !rd_valid && out_valid)
    else $error("ROM stage word not moved to output");

endmodule

`default_nettype wire
